@@ hdl/las_pkg.sv @@
// ---------------------------------------------------------------------------
// las_pkg: shared types and constants of the lift alarm sequencer
// Word layouts, command and register codes, and the player frame builder.
// ---------------------------------------------------------------------------
package las_pkg;

    localparam int LAS_FRAME_LENGTH = 8;
    localparam int LAS_MAX_FRAMES   = 4;
    localparam int LAS_POS_W        = $clog2(LAS_FRAME_LENGTH);
    localparam int LAS_FRM_W        = $clog2(LAS_MAX_FRAMES);
    localparam int LAS_IDX_W        = LAS_POS_W + LAS_FRM_W;
    localparam int LAS_QUEUE_DEPTH  = 2;

    // configuration port
    localparam int LAS_CFG_IDX_W  = 2;
    localparam int LAS_CFG_DATA_W = 16;
    localparam logic [LAS_CFG_IDX_W-1:0] CFG_REPLAY_GAP   = 2'd0;
    localparam logic [LAS_CFG_IDX_W-1:0] CFG_START_VOLUME = 2'd1;
    localparam logic [LAS_CFG_IDX_W-1:0] CFG_VOLUME_STEP  = 2'd2;
    localparam logic [LAS_CFG_IDX_W-1:0] CFG_VOLUME_MAX   = 2'd3;

    localparam logic [15:0] RST_REPLAY_GAP   = 16'd2000;
    localparam logic [4:0]  RST_START_VOLUME = 5'd20;
    localparam logic [4:0]  RST_VOLUME_STEP  = 5'd5;
    localparam logic [4:0]  RST_VOLUME_MAX   = 5'd30;

    // motor direction
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    // player state
    localparam logic [1:0] ST_STARTING = 2'd0;
    localparam logic [1:0] ST_PLAYING  = 2'd1;
    localparam logic [1:0] ST_PENDING  = 2'd2;
    localparam logic [1:0] ST_IDLE     = 2'd3;

    // command bytes
    localparam logic [7:0] CMD_ZERO   = 8'h30;
    localparam logic [7:0] CMD_ONE    = 8'h31;
    localparam logic [7:0] CMD_NINE   = 8'h39;
    localparam logic [7:0] CMD_UP     = 8'h75;
    localparam logic [7:0] CMD_DOWN   = 8'h64;
    localparam logic [7:0] CMD_MUTE   = 8'h6D;
    localparam logic [7:0] CMD_STOP   = 8'h73;

    // frame kinds, in the order a play sequence sends them
    localparam logic [LAS_FRM_W-1:0] FRM_RESET  = 2'd0;
    localparam logic [LAS_FRM_W-1:0] FRM_VOLUME = 2'd1;
    localparam logic [LAS_FRM_W-1:0] FRM_PLAY   = 2'd2;
    localparam logic [LAS_FRM_W-1:0] FRM_STOP   = 2'd3;

    localparam logic [7:0] OP_RESET  = 8'h0B;
    localparam logic [7:0] OP_VOLUME = 8'h06;
    localparam logic [7:0] OP_PLAY   = 8'h03;
    localparam logic [7:0] OP_STOP   = 8'h0E;

    localparam logic [7:0] FB_START   = 8'h7E;
    localparam logic [7:0] FB_VERSION = 8'hFF;
    localparam logic [7:0] FB_LENGTH  = 8'h06;
    localparam logic [7:0] FB_END     = 8'hEF;

    typedef struct packed {
        logic       limit_top_low;
        logic       limit_bottom_low;
        logic       busy_rise;
        logic       cmd_valid;
        logic [7:0] cmd_byte;
    } t_in_word;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       motor_a;
        logic       motor_b;
        logic       motor_enable;
        logic [1:0] sound_state;
        logic       alarm_on;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic       motor_a;
        logic       motor_b;
        logic       motor_enable;
        logic [1:0] sound_state;
        logic       alarm_on;
    } t_status;

    // one tick's work for the frame sender
    typedef struct packed {
        logic       play_en;
        logic       stop_en;
        logic [4:0] volume;
        logic [3:0] track;
        t_status    status;
    } t_job;

    function automatic logic [7:0] frame_byte(
        input logic [LAS_FRM_W-1:0] kind,
        input logic [4:0]           volume,
        input logic [3:0]           track,
        input logic [LAS_POS_W-1:0] pos
    );
        logic [7:0] op;
        logic [7:0] arg;
        logic [7:0] b;
        op  = OP_STOP;
        arg = 8'h00;
        case (kind)
            FRM_RESET:  op = OP_RESET;
            FRM_VOLUME: begin
                op  = OP_VOLUME;
                arg = {3'b000, volume};
            end
            FRM_PLAY: begin
                op  = OP_PLAY;
                arg = {4'b0000, track};
            end
            default:    op = OP_STOP;
        endcase
        case (pos)
            3'd0:    b = FB_START;
            3'd1:    b = FB_VERSION;
            3'd2:    b = FB_LENGTH;
            3'd3:    b = op;
            3'd6:    b = arg;
            3'd7:    b = FB_END;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ hdl/las_front.sv @@
// ---------------------------------------------------------------------------
// las_front: tick decoder
// Holds the motor, player and alarm state and the configuration registers.
// Each accepted tick updates the state and queues a job that
// names the frames to send and the status at the end of the tick.
// ---------------------------------------------------------------------------
module las_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  las_pkg::t_in_word                 i_in_word,
    input  logic                              i_cfg_we,
    input  logic [las_pkg::LAS_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [las_pkg::LAS_CFG_DATA_W-1:0] i_cfg_data,
    output las_pkg::t_job                     o_job
);
    import las_pkg::*;

    logic [15:0] r_gap;
    logic [4:0]  r_start_vol;
    logic [4:0]  r_step;
    logic [4:0]  r_vol_max;

    logic [1:0]  r_dir,   n_dir;
    logic [1:0]  r_ps,    n_ps;
    logic        r_alarm, n_alarm;
    logic [3:0]  r_trk,   n_trk;
    logic        r_known, n_known;
    logic [4:0]  r_vol,   n_vol;
    logic [15:0] r_wait,  n_wait;

    logic        play;
    logic        stop;
    logic [4:0]  play_vol;
    logic [3:0]  play_trk;
    logic [5:0]  raised;
    logic [7:0]  cmd;

    always_comb begin
        n_dir    = r_dir;
        n_ps     = r_ps;
        n_alarm  = r_alarm;
        n_trk    = r_trk;
        n_known  = r_known;
        n_vol    = r_vol;
        n_wait   = r_wait;
        play     = 1'b0;
        stop     = 1'b0;
        play_vol = r_vol;
        play_trk = r_trk;
        raised   = {1'b0, r_vol} + {1'b0, r_step};
        cmd      = i_in_word.cmd_byte;

        if (i_in_word.busy_rise && r_ps == ST_PLAYING) begin
            n_wait = 16'd0;
            n_ps   = ST_PENDING;
        end

        // only the limit ahead of the motion counts
        if (n_dir == DIR_UP && i_in_word.limit_top_low) begin
            n_dir = DIR_STOP;
        end
        if (n_dir == DIR_DOWN && i_in_word.limit_bottom_low) begin
            n_dir = DIR_STOP;
        end

        if (n_ps == ST_STARTING) begin
            if (r_known) begin
                play = 1'b1;
                n_ps = ST_PLAYING;
            end else begin
                n_ps = ST_IDLE;
            end
        end else if (n_ps == ST_PENDING) begin
            if (n_wait >= r_gap && r_alarm) begin
                if (raised > {1'b0, r_vol_max}) begin
                    raised = {1'b0, r_vol_max};
                end
                n_vol    = raised[4:0];
                play     = 1'b1;
                play_vol = raised[4:0];
                n_ps     = ST_PLAYING;
            end else if (n_wait != 16'hFFFF) begin
                n_wait = n_wait + 16'd1;
            end
        end

        if (i_in_word.cmd_valid) begin
            if (cmd inside {[CMD_ONE:CMD_NINE]}) begin
                n_alarm = 1'b1;
                n_trk   = 4'(cmd - CMD_ZERO);
                n_known = 1'b1;
                n_vol   = r_start_vol;
                if (n_ps == ST_IDLE) begin
                    play     = 1'b1;
                    play_vol = r_start_vol;
                    play_trk = 4'(cmd - CMD_ZERO);
                    n_ps     = ST_PLAYING;
                end
                n_dir = DIR_UP;
            end else if (cmd == CMD_UP) begin
                n_dir = DIR_UP;
            end else if (cmd == CMD_DOWN) begin
                n_alarm = 1'b0;
                n_ps    = ST_IDLE;
                stop    = 1'b1;
                n_dir   = DIR_DOWN;
            end else if (cmd == CMD_MUTE) begin
                n_alarm = 1'b0;
                n_ps    = ST_IDLE;
                stop    = 1'b1;
            end else if (cmd == CMD_STOP) begin
                n_dir = DIR_STOP;
            end
        end

        o_job.play_en             = play;
        o_job.stop_en             = stop;
        o_job.volume              = play_vol;
        o_job.track               = play_trk;
        o_job.status.motor_a      = (n_dir == DIR_DOWN);
        o_job.status.motor_b      = (n_dir == DIR_UP);
        o_job.status.motor_enable = (n_dir != DIR_STOP);
        o_job.status.sound_state  = n_ps;
        o_job.status.alarm_on     = n_alarm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap       <= RST_REPLAY_GAP;
            r_start_vol <= RST_START_VOLUME;
            r_step      <= RST_VOLUME_STEP;
            r_vol_max   <= RST_VOLUME_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_REPLAY_GAP:   r_gap       <= i_cfg_data;
                CFG_START_VOLUME: r_start_vol <= i_cfg_data[4:0];
                CFG_VOLUME_STEP:  r_step      <= i_cfg_data[4:0];
                CFG_VOLUME_MAX:   r_vol_max   <= i_cfg_data[4:0];
                default:          r_gap       <= r_gap;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir   <= DIR_STOP;
            r_ps    <= ST_STARTING;
            r_alarm <= 1'b0;
            r_trk   <= 4'd0;
            r_known <= 1'b0;
            r_vol   <= 5'd0;
            r_wait  <= 16'd0;
        end else if (i_accept) begin
            r_dir   <= n_dir;
            r_ps    <= n_ps;
            r_alarm <= n_alarm;
            r_trk   <= n_trk;
            r_known <= n_known;
            r_vol   <= n_vol;
            r_wait  <= n_wait;
        end
    end

endmodule

@@ hdl/las_queue.sv @@
// ---------------------------------------------------------------------------
// las_queue: job queue between decoder and frame sender
// Shift queue: the head is always slot zero, a pop moves every slot down.
// ---------------------------------------------------------------------------
module las_queue #(
    parameter int DEPTH = las_pkg::LAS_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  las_pkg::t_job i_job,
    input  logic          i_pop,
    output las_pkg::t_job o_head,
    output logic          o_full,
    output logic          o_empty
);
    import las_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_slot [DEPTH];
    logic [CW-1:0] r_count;
    logic [CW-1:0] wr_pos;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[0];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign wr_pos  = do_pop ? r_count - CW'(1) : r_count;

    for (genvar i = 0; i < DEPTH; i++) begin : g_slot
        always_ff @(posedge i_clk) begin
            if (do_push && wr_pos == CW'(i)) begin
                r_slot[i] <= i_job;
            end else if (do_pop) begin
                if (i < DEPTH - 1) begin
                    r_slot[i] <= r_slot[(i < DEPTH - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (do_push && !do_pop) begin
            r_count <= r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            r_count <= r_count - CW'(1);
        end
    end

endmodule

@@ hdl/las_back.sv @@
// ---------------------------------------------------------------------------
// las_back: frame sender
// Walks the head job byte by byte into the output register, one word a
// cycle unless the output is held, and pops the job with its final word.
// ---------------------------------------------------------------------------
module las_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  las_pkg::t_job     i_head,
    input  logic              i_head_empty,
    output logic              o_head_pop,
    output las_pkg::t_out_word o_out_word,
    output logic              o_empty,
    input  logic              i_pop
);
    import las_pkg::*;

    logic [LAS_IDX_W-1:0] r_idx;
    logic                 r_valid;
    t_out_word            r_out;
    t_out_word            n_out;
    logic                 load;
    logic                 quiet;
    logic                 last;
    logic [LAS_FRM_W-1:0] frm;
    logic [LAS_FRM_W-1:0] last_frm;
    logic [LAS_FRM_W-1:0] kind;

    assign frm      = r_idx[LAS_POS_W +: LAS_FRM_W];
    assign quiet    = !i_head.play_en && !i_head.stop_en;
    // a play sequence is three frames, a trailing stop makes four
    assign last_frm = i_head.play_en ? (i_head.stop_en ? FRM_STOP : FRM_PLAY) : FRM_RESET;
    assign kind     = i_head.play_en ? frm : FRM_STOP;
    assign last     = quiet || (frm == last_frm && (&r_idx[LAS_POS_W-1:0]));
    assign load     = !i_head_empty && (!r_valid || i_pop);

    always_comb begin
        n_out.tx_valid     = !quiet;
        n_out.tx_byte      = quiet ? 8'h00
                           : frame_byte(kind, i_head.volume, i_head.track,
                                        r_idx[LAS_POS_W-1:0]);
        n_out.motor_a      = i_head.status.motor_a;
        n_out.motor_b      = i_head.status.motor_b;
        n_out.motor_enable = i_head.status.motor_enable;
        n_out.sound_state  = i_head.status.sound_state;
        n_out.alarm_on     = i_head.status.alarm_on;
        n_out.last         = last;
    end

    assign o_head_pop = load && last;
    assign o_out_word = r_out;
    assign o_empty    = !r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last ? '0 : r_idx + LAS_IDX_W'(1);
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

endmodule

@@ hdl/lift_alarm_sequencer.sv @@
// ---------------------------------------------------------------------------
// lift_alarm_sequencer: lift motor and sound alarm sequencer
// Takes one word per millisecond tick and returns the player frame bytes
// that the tick causes, each with the motor and alarm status.
// ---------------------------------------------------------------------------
// A tick word is taken whenever full is low: the decoder updates the motor,
// player and alarm state at once and queues a job. The frame sender drains
// jobs one result word per cycle while pop keeps the output register free:
// a quiet tick gives one word with tx_valid low, any other tick eight words
// per frame, up to four frames; that sender is what sets the sustained rate.
// The last word of each tick has last set. The queue holds QUEUE_DEPTH jobs,
// plus the one in the output register.
module lift_alarm_sequencer #(
    parameter int QUEUE_DEPTH = las_pkg::LAS_QUEUE_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  las_pkg::t_in_word                  i_in_word,
    output logic                               empty,
    input  logic                               pop,
    output las_pkg::t_out_word                 o_out_word,
    input  logic                               i_cfg_we,
    input  logic [las_pkg::LAS_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [las_pkg::LAS_CFG_DATA_W-1:0] i_cfg_data
);
    import las_pkg::*;

    t_job job;
    t_job head;
    logic accept;
    logic head_empty;
    logic head_pop;

    assign accept = push && !full;

    las_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_job       (job)
    );

    las_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_job   (job),
        .i_pop   (head_pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (head_empty)
    );

    las_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_empty (head_empty),
        .o_head_pop   (head_pop),
        .o_out_word   (o_out_word),
        .o_empty      (empty),
        .i_pop        (pop)
    );

endmodule

@@ tb/lift_alarm_sequencer_tb.sv @@
// ---------------------------------------------------------------------------
// lift_alarm_sequencer_tb: self-checking bench for the lift alarm sequencer
// Drives millisecond tick words through the input queue, predicts every
// result word with a cycle-free model of the motor, player and alarm state,
// and compares each popped word field by field. Both handshakes idle at
// random; registers are rewritten between phases while the block is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lift_alarm_sequencer_tb;

    import las_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int IDLE_PCT      = 38;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      push        = 1'b0;
    logic                      full;
    t_in_word                  i_in_word   = '0;
    logic                      empty;
    logic                      pop         = 1'b0;
    t_out_word                 o_out_word;
    logic                      i_cfg_we    = 1'b0;
    logic [LAS_CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [LAS_CFG_DATA_W-1:0] i_cfg_data  = '0;

    int unsigned src_idle_pct  = IDLE_PCT;
    int unsigned sink_idle_pct = IDLE_PCT;
    int unsigned error_count   = 0;

    // predicted result words, oldest first
    t_out_word  expected_words[$];
    logic [7:0] frame_bytes[$];

    // register copies
    logic [15:0] cfg_gap;
    logic [4:0]  cfg_start_vol;
    logic [4:0]  cfg_step;
    logic [4:0]  cfg_ceiling;

    // lift and player state
    logic [1:0]  motor_dir;
    logic [1:0]  snd_state;
    logic        alarm_armed;
    logic [3:0]  track_no;
    logic        track_set;
    logic [4:0]  play_vol;
    logic [15:0] wait_cnt;

    lift_alarm_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_word   (i_in_word),
        .empty       (empty),
        .pop         (pop),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // -----------------------------------------------------------------------
    // prediction
    // -----------------------------------------------------------------------
    task automatic reset_model();
        cfg_gap       = RST_REPLAY_GAP;
        cfg_start_vol = RST_START_VOLUME;
        cfg_step      = RST_VOLUME_STEP;
        cfg_ceiling   = RST_VOLUME_MAX;
        motor_dir     = DIR_STOP;
        snd_state     = ST_STARTING;
        alarm_armed   = 1'b0;
        track_no      = '0;
        track_set     = 1'b0;
        play_vol      = '0;
        wait_cnt      = '0;
    endtask

    task automatic add_frame(input logic [7:0] op, input logic [7:0] arg);
        frame_bytes.push_back(FB_START);
        frame_bytes.push_back(FB_VERSION);
        frame_bytes.push_back(FB_LENGTH);
        frame_bytes.push_back(op);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(arg);
        frame_bytes.push_back(FB_END);
    endtask

    task automatic add_play_sequence();
        add_frame(OP_RESET, 8'h00);
        add_frame(OP_VOLUME, {3'b000, play_vol});
        add_frame(OP_PLAY, {4'b0000, track_no});
    endtask

    task automatic silence_alarm();
        alarm_armed = 1'b0;
        snd_state   = ST_IDLE;
        add_frame(OP_STOP, 8'h00);
    endtask

    task automatic predict_tick(input t_in_word w);
        logic [5:0] raised;
        t_out_word  r;
        int         n;
        frame_bytes.delete();

        // a finished track counts only while playing
        if (w.busy_rise && snd_state == ST_PLAYING) begin
            wait_cnt  = '0;
            snd_state = ST_PENDING;
        end

        if (motor_dir == DIR_UP && w.limit_top_low) motor_dir = DIR_STOP;
        if (motor_dir == DIR_DOWN && w.limit_bottom_low) motor_dir = DIR_STOP;

        case (snd_state)
            ST_STARTING: begin
                if (track_set) begin
                    add_play_sequence();
                    snd_state = ST_PLAYING;
                end else begin
                    snd_state = ST_IDLE;
                end
            end
            ST_PENDING: begin
                if (wait_cnt >= cfg_gap && alarm_armed) begin
                    raised = {1'b0, play_vol} + {1'b0, cfg_step};
                    if (raised > {1'b0, cfg_ceiling}) raised = {1'b0, cfg_ceiling};
                    play_vol = raised[4:0];
                    add_play_sequence();
                    snd_state = ST_PLAYING;
                end else if (wait_cnt != 16'hFFFF) begin
                    wait_cnt = wait_cnt + 16'd1;
                end
            end
            default: ;
        endcase

        if (w.cmd_valid) begin
            if (w.cmd_byte >= CMD_ONE && w.cmd_byte <= CMD_NINE) begin
                alarm_armed = 1'b1;
                track_no    = 4'(w.cmd_byte - CMD_ZERO);
                track_set   = 1'b1;
                play_vol    = cfg_start_vol;
                if (snd_state == ST_IDLE) begin
                    add_play_sequence();
                    snd_state = ST_PLAYING;
                end
                motor_dir = DIR_UP;
            end else if (w.cmd_byte == CMD_UP) begin
                motor_dir = DIR_UP;
            end else if (w.cmd_byte == CMD_DOWN) begin
                silence_alarm();
                motor_dir = DIR_DOWN;
            end else if (w.cmd_byte == CMD_MUTE) begin
                silence_alarm();
            end else if (w.cmd_byte == CMD_STOP) begin
                motor_dir = DIR_STOP;
            end
        end

        // a quiet tick still yields one word
        n = (frame_bytes.size() > 0) ? frame_bytes.size() : 1;
        for (int k = 0; k < n; k++) begin
            r.tx_valid     = (frame_bytes.size() > 0);
            r.tx_byte      = (frame_bytes.size() > 0) ? frame_bytes[k] : 8'h00;
            r.motor_a      = (motor_dir == DIR_DOWN);
            r.motor_b      = (motor_dir == DIR_UP);
            r.motor_enable = (motor_dir != DIR_STOP);
            r.sound_state  = snd_state;
            r.alarm_on     = alarm_armed;
            r.last         = (k == n - 1);
            expected_words.push_back(r);
        end
    endtask

    // -----------------------------------------------------------------------
    // result side: random pop, compare with the oldest prediction
    // -----------------------------------------------------------------------
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_word want;
        if (i_rst_n && pop && !empty) begin
            if (expected_words.size() == 0) begin
                $error("word %0h arrived with nothing expected", o_out_word);
                error_count++;
            end else begin
                want = expected_words.pop_front();
                check_field("tx_valid", 32'(want.tx_valid), 32'(o_out_word.tx_valid));
                check_field("tx_byte", 32'(want.tx_byte), 32'(o_out_word.tx_byte));
                check_field("motor_a", 32'(want.motor_a), 32'(o_out_word.motor_a));
                check_field("motor_b", 32'(want.motor_b), 32'(o_out_word.motor_b));
                check_field("motor_enable", 32'(want.motor_enable),
                            32'(o_out_word.motor_enable));
                check_field("sound_state", 32'(want.sound_state),
                            32'(o_out_word.sound_state));
                check_field("alarm_on", 32'(want.alarm_on), 32'(o_out_word.alarm_on));
                check_field("last", 32'(want.last), 32'(o_out_word.last));
            end
        end
        pop <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // -----------------------------------------------------------------------
    // input side
    // -----------------------------------------------------------------------
    // Leaves push high on return so back-to-back words go in without push dropping.
    task automatic send_tick(input t_in_word w);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_tick(w);
    endtask

    function automatic t_in_word make_tick(input logic top, input logic bottom,
                                           input logic busy, input logic valid,
                                           input logic [7:0] cmd);
        t_in_word w;
        w.limit_top_low    = top;
        w.limit_bottom_low = bottom;
        w.busy_rise        = busy;
        w.cmd_valid        = valid;
        w.cmd_byte         = cmd;
        return w;
    endfunction

    function automatic t_in_word random_tick();
        t_in_word    w;
        int unsigned pick;
        w.limit_top_low    = ($urandom_range(0, 4) == 0);
        w.limit_bottom_low = ($urandom_range(0, 4) == 0);
        w.busy_rise        = ($urandom_range(0, 3) == 0);
        w.cmd_valid        = 1'b1;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            w.cmd_byte = CMD_ONE + 8'($urandom_range(0, 8));
        end else if (pick < 20) begin
            w.cmd_byte = CMD_UP;
        end else if (pick < 24) begin
            w.cmd_byte = CMD_DOWN;
        end else if (pick < 28) begin
            w.cmd_byte = CMD_MUTE;
        end else if (pick < 34) begin
            w.cmd_byte = CMD_STOP;
        end else if (pick < 42) begin
            w.cmd_byte = 8'($urandom);
        end else begin
            w.cmd_valid = 1'b0;
            w.cmd_byte  = 8'($urandom);
        end
        return w;
    endfunction

    // Hold the sender until every predicted word has been popped.
    task automatic wait_drained();
        push <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Leaves the write enable high; set_config drops it after the last write.
    task automatic write_reg(input logic [LAS_CFG_IDX_W-1:0] idx,
                             input logic [LAS_CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_REPLAY_GAP:   cfg_gap       = data;
            CFG_START_VOLUME: cfg_start_vol = data[4:0];
            CFG_VOLUME_STEP:  cfg_step      = data[4:0];
            CFG_VOLUME_MAX:   cfg_ceiling   = data[4:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] gap, input logic [4:0] start_vol,
                              input logic [4:0] step, input logic [4:0] ceiling);
        wait_drained();
        write_reg(CFG_REPLAY_GAP, gap);
        write_reg(CFG_START_VOLUME, {11'd0, start_vol});
        write_reg(CFG_VOLUME_STEP, {11'd0, step});
        write_reg(CFG_VOLUME_MAX, {11'd0, ceiling});
        i_cfg_we <= 1'b0;
    endtask

    // -----------------------------------------------------------------------
    // tests
    // -----------------------------------------------------------------------
    task automatic test_power_up();
        // first tick leaves starting with no track chosen
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        // finished track while idle, unknown byte: both ignored
        send_tick(make_tick(1'b1, 1'b1, 1'b1, 1'b1, 8'hFF));
    endtask

    task automatic test_motor_limits();
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b1, CMD_UP));
        send_tick(make_tick(1'b1, 1'b1, 1'b0, 1'b0, 8'h00));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b1, CMD_DOWN));
        // top limit means nothing while moving down
        send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
        send_tick(make_tick(1'b0, 1'b1, 1'b0, 1'b0, 8'h00));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b1, CMD_UP));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b1, CMD_STOP));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, CMD_UP));
    endtask

    task automatic test_arm_and_stop();
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b1, CMD_ONE));
        send_tick(make_tick(1'b0, 1'b0, 1'b1, 1'b0, 8'h00));
        // arm while pending: stored, nothing sent
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b1, CMD_NINE));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b1, CMD_MUTE));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b1, CMD_NINE));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b1, CMD_DOWN));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b1, CMD_ZERO));
    endtask

    task automatic test_zero_gap_replay();
        set_config(16'd0, 5'd5, 5'd30, 5'd30);
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b1, CMD_ONE + 8'd2));
        send_tick(make_tick(1'b0, 1'b0, 1'b1, 1'b0, 8'h00));
        // replay and stop frame in one tick: the longest burst
        send_tick(make_tick(1'b0, 1'b0, 1'b1, 1'b1, CMD_MUTE));
    endtask

    task automatic test_volume_ceiling();
        // start volume above the ceiling stays until the first raise
        set_config(16'd1, 5'd30, 5'd1, 5'd10);
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b1, CMD_ONE + 8'd1));
        send_tick(make_tick(1'b0, 1'b0, 1'b1, 1'b0, 8'h00));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        send_tick(make_tick(1'b1, 1'b0, 1'b1, 1'b0, 8'h00));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
    endtask

    task automatic run_random_phase(input int count, input bit pause_midway);
        for (int i = 0; i < count; i++) begin
            if (pause_midway && i == count / 2) wait_drained();
            send_tick(random_tick());
        end
    endtask

    task automatic test_random_ticks();
        set_config(16'd0, 5'd0, 5'd0, 5'd0);
        run_random_phase(20, 1'b0);
        set_config(16'hFFFF, 5'd30, 5'd30, 5'd30);
        run_random_phase(15, 1'b0);

        // long stretch with both sides running flat out
        set_config(16'd1, RST_START_VOLUME, RST_VOLUME_STEP, RST_VOLUME_MAX);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_random_phase(30, 1'b0);
        src_idle_pct  = IDLE_PCT;
        sink_idle_pct = IDLE_PCT;

        for (int p = 0; p < 3; p++) begin
            set_config(16'($urandom_range(0, 6)), 5'($urandom_range(0, 30)),
                       5'($urandom_range(0, 30)), 5'($urandom_range(0, 30)));
            run_random_phase(20, p == 1);
        end
    endtask

    initial begin
        reset_model();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_power_up();
        test_motor_limits();
        test_arm_and_stop();
        test_zero_gap_replay();
        test_volume_ceiling();
        test_random_ticks();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_words.size() != 0) begin
            $error("%0d predicted words never arrived", expected_words.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
